// File: src/mlp_pkg.sv
// shared types, constants and the sigmoid knot table for the mlp inference unit
// no dependencies
package mlp_pkg;

  localparam int MAX_NEURONS = 64;
  localparam int MAX_LAYERS  = 4;
  localparam int VALUE_BITS  = 16;
  localparam int SIG_DEPTH   = 256;

  localparam int NRN_W  = $clog2(MAX_NEURONS);
  localparam int LYR_W  = $clog2(MAX_LAYERS);
  localparam int CNT_W  = NRN_W + 1;
  localparam int WADR_W = LYR_W + NRN_W;
  localparam int ACC_W  = 2 * VALUE_BITS + NRN_W + 2;
  localparam int WID_W  = 7;
  localparam int HLC_W  = 3;
  localparam int CFG_W  = 16;
  localparam int CIDX_W = 3;

  localparam logic [1:0] OP_WEIGHT = 2'd0;
  localparam logic [1:0] OP_BIAS   = 2'd1;
  localparam logic [1:0] OP_FEED   = 2'd2;

  localparam logic [CIDX_W-1:0] CFG_LAYERS  = 3'd0;
  localparam logic [CIDX_W-1:0] CFG_WIN     = 3'd1;
  localparam logic [CIDX_W-1:0] CFG_WH1     = 3'd2;
  localparam logic [CIDX_W-1:0] CFG_WH2     = 3'd3;
  localparam logic [CIDX_W-1:0] CFG_WH3     = 3'd4;
  localparam logic [CIDX_W-1:0] CFG_WH4     = 3'd5;
  localparam logic [CIDX_W-1:0] CFG_OBIAS   = 3'd6;

  typedef enum logic [3:0] {
    S_IDLE, S_INIT, S_MAC, S_D1, S_D2, S_FIN, S_SHIFT, S_SIG1, S_SIG2
  } state_t;

  typedef struct packed {
    logic              clr;
    logic              rd;
    logic              mul;
    logic              acc;
    logic              fin;
    logic              shift;
    logic [LYR_W-1:0]  layer;
    logic [NRN_W-1:0]  row;
  } cell_ctl_t;

  function automatic logic [15:0] knot(input logic [4:0] k);
    logic [15:0] v;
    case (k)
      5'd0:  v = 16'd32767;
      5'd1:  v = 16'd40793;
      5'd2:  v = 16'd47910;
      5'd3:  v = 16'd53580;
      5'd4:  v = 16'd57723;
      5'd5:  v = 16'd60564;
      5'd6:  v = 16'd62427;
      5'd7:  v = 16'd63614;
      5'd8:  v = 16'd64356;
      5'd9:  v = 16'd64815;
      5'd10: v = 16'd65096;
      5'd11: v = 16'd65268;
      5'd12: v = 16'd65373;
      5'd13: v = 16'd65436;
      5'd14: v = 16'd65475;
      5'd15: v = 16'd65499;
      default: v = 16'd65513;
    endcase
    return v;
  endfunction

endpackage

// File: src/mlp_cell.sv
// one neuron cell: weight column memory, bias registers, multiply-accumulate
// and a result register that shifts toward cell zero; depends on mlp_pkg
module mlp_cell (
  input  logic                                 clk,
  input  mlp_pkg::cell_ctl_t                   ctl,
  input  logic                                 w_we,
  input  logic                                 b_we,
  input  logic [mlp_pkg::LYR_W-1:0]            wr_layer,
  input  logic [mlp_pkg::NRN_W-1:0]            wr_row,
  input  logic signed [mlp_pkg::VALUE_BITS-1:0] wr_val,
  input  logic signed [mlp_pkg::VALUE_BITS-1:0] act,
  input  logic signed [mlp_pkg::VALUE_BITS-1:0] shift_in,
  output logic signed [mlp_pkg::VALUE_BITS-1:0] res
);
  import mlp_pkg::*;

  localparam logic signed [ACC_W-1:0] HI = ACC_W'((64'sd1 <<< (VALUE_BITS - 1)) - 1);

  logic signed [VALUE_BITS-1:0]   wmem [MAX_LAYERS*MAX_NEURONS];
  logic signed [VALUE_BITS-1:0]   bias_r [MAX_LAYERS];
  logic signed [VALUE_BITS-1:0]   w_r;
  logic signed [2*VALUE_BITS-1:0] prod_r;
  logic signed [ACC_W-1:0]        acc_r;
  logic signed [VALUE_BITS-1:0]   res_r;
  logic signed [ACC_W-1:0]        sh;
  logic signed [VALUE_BITS-1:0]   res_nxt;

  always_ff @(posedge clk) begin
    if (w_we) begin
      wmem[{wr_layer, wr_row}] <= wr_val;
    end
    if (ctl.rd) begin
      w_r <= wmem[{ctl.layer, ctl.row}];
    end
  end

  always_ff @(posedge clk) begin
    if (b_we) begin
      bias_r[wr_layer] <= wr_val;
    end
  end

  always_comb begin
    sh = acc_r >>> 8;
    if (sh <= 0) begin
      res_nxt = '0;
    end else if (sh > HI) begin
      res_nxt = HI[VALUE_BITS-1:0];
    end else begin
      res_nxt = sh[VALUE_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.mul) begin
      prod_r <= w_r * act;
    end
    if (ctl.clr) begin
      acc_r <= ACC_W'(bias_r[ctl.layer]) <<< 8;
    end else if (ctl.acc) begin
      acc_r <= acc_r + ACC_W'(prod_r);
    end
    if (ctl.fin) begin
      res_r <= res_nxt;
    end else if (ctl.shift) begin
      res_r <= shift_in;
    end
  end

  assign res = res_r;

endmodule

// File: src/mlp_sigmoid.sv
// two-step table sigmoid: clamp and knot selection, then interpolation
// depends on mlp_pkg
module mlp_sigmoid (
  input  logic                                  clk,
  input  logic                                  load,
  input  logic signed [mlp_pkg::VALUE_BITS-1:0] act0,
  input  logic signed [15:0]                    bias,
  output logic [15:0]                           score
);
  import mlp_pkg::*;

  logic signed [VALUE_BITS:0] sum;
  logic signed [12:0]         xc;
  logic [11:0]                u;
  logic [31:0]                idxw;
  logic [31:0]                leftw;
  logic signed [13:0]         left;
  logic [11:0]                mag;
  logic [4:0]                 k_r;
  logic [6:0]                 f_r;
  logic                       neg_r;
  logic [15:0]                k0;
  logic [15:0]                k1;
  logic [22:0]                step;
  logic [15:0]                v;

  always_comb begin
    sum = (VALUE_BITS+1)'(act0) + (VALUE_BITS+1)'(bias);
    if (sum < -2048) begin
      xc = -13'sd2048;
    end else if (sum > 2047) begin
      xc = 13'sd2047;
    end else begin
      xc = 13'(sum);
    end
    u     = 12'(xc + 13'sd2048);
    idxw  = (32'(u) * 32'(SIG_DEPTH)) >> 12;
    leftw = (idxw * 32'd4096) / SIG_DEPTH;
    left  = 14'(leftw) - 14'sd2048;
    mag   = (left < 0) ? 12'(-left) : 12'(left);
  end

  always_ff @(posedge clk) begin
    if (load) begin
      k_r   <= mag[11:7];
      f_r   <= mag[6:0];
      neg_r <= (left < 0);
    end
  end

  always_comb begin
    k0   = knot(k_r);
    k1   = knot(k_r + 5'd1);
    step = 23'(k1 - k0) * 23'(f_r);
    if (k_r >= 5'd16) begin
      v = knot(5'd16);
    end else begin
      v = k0 + 16'(step >> 7);
    end
    score = neg_r ? (16'hFFFF - v) : v;
  end

endmodule

// File: src/mlp_inference_relu_sigmoid_unit.sv
// dense relu network with table sigmoid output, Q8.8 fixed point
// top level: sequencer, feature and hidden memories, a row of mlp_cell,
// mlp_sigmoid; depends on mlp_pkg
//
// requests enter on in_valid/in_stall: weight writes, bias writes and
// features, taken back to back while idle. a feature with last set starts
// one evaluation, during which in_stall stays high.
// each hidden layer runs a row of cells, one per destination neuron:
// the source activations are broadcast one per cycle to all cells, each
// doing one multiply-accumulate per cycle, then the results shift out
// through the row into the hidden memory, one neuron per cycle.
// each layer runs S_INIT, S_MAC, S_D1, S_D2, S_FIN and S_SHIFT; after the
// last layer, S_SIG1 loads the sigmoid and S_SIG2 the output register.
// the score waits in an output register until out_stall is low; a new
// evaluation only stalls at its end if the previous score is still held.
// reset restores the register defaults, empties the output register and
// clears all features to zero; weights and biases must be written first.
// features are cleared again after each evaluation.
module mlp_inference_relu_sigmoid_unit (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [1:0]                 in_op,
  input  logic [1:0]                 in_layer_index,
  input  logic [5:0]                 in_row_index,
  input  logic [5:0]                 in_col_index,
  input  logic signed [15:0]         in_value,
  input  logic                       in_last,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [15:0]                out_score,
  output logic                       out_detected,
  input  logic                       cfg_we,
  input  logic [mlp_pkg::CIDX_W-1:0] cfg_index,
  input  logic [mlp_pkg::CFG_W-1:0]  cfg_data
);
  import mlp_pkg::*;

  logic [HLC_W-1:0]       hlc_r;
  logic [WID_W-1:0]       win_r;
  logic [WID_W-1:0]       wh_r [4];
  logic signed [15:0]     obias_r;

  state_t                 state_r, state_nxt;
  logic [LYR_W-1:0]       layer_r, layer_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [WID_W-1:0]       nsrc_r, nsrc_nxt;
  logic                   v1_r, v2_r;
  logic                   sel_r;
  logic                   out_valid_r;
  logic [15:0]            score_r;
  logic signed [VALUE_BITS-1:0] act0_r;

  logic signed [VALUE_BITS-1:0] feat [MAX_NEURONS];
  logic [MAX_NEURONS-1:0]       fv_r;
  logic signed [VALUE_BITS-1:0] hid [MAX_NEURONS];
  logic signed [VALUE_BITS-1:0] feat_q, hid_q;
  logic                         fv_q;
  logic signed [VALUE_BITS-1:0] act;

  logic                   accept;
  logic [LYR_W-1:0]       last_layer;
  logic [WID_W-1:0]       ndst;
  logic                   fv_clr;
  logic                   sig_load;
  logic                   out_load;
  logic                   out_free;
  logic [15:0]            score;
  cell_ctl_t              ctl;

  logic signed [VALUE_BITS-1:0] res [MAX_NEURONS+1];

  function automatic logic [WID_W-1:0] clampw(input logic [WID_W-1:0] w);
    logic [WID_W-1:0] r;
    if (w == '0) begin
      r = WID_W'(1);
    end else if (w > WID_W'(MAX_NEURONS)) begin
      r = WID_W'(MAX_NEURONS);
    end else begin
      r = w;
    end
    return r;
  endfunction

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hlc_r   <= HLC_W'(1);
      win_r   <= WID_W'(64);
      wh_r[0] <= WID_W'(64);
      wh_r[1] <= WID_W'(64);
      wh_r[2] <= WID_W'(64);
      wh_r[3] <= WID_W'(64);
      obias_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_LAYERS: hlc_r   <= cfg_data[HLC_W-1:0];
        CFG_WIN:    win_r   <= cfg_data[WID_W-1:0];
        CFG_WH1:    wh_r[0] <= cfg_data[WID_W-1:0];
        CFG_WH2:    wh_r[1] <= cfg_data[WID_W-1:0];
        CFG_WH3:    wh_r[2] <= cfg_data[WID_W-1:0];
        CFG_WH4:    wh_r[3] <= cfg_data[WID_W-1:0];
        CFG_OBIAS:  obias_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (hlc_r == '0) begin
      last_layer = '0;
    end else if (hlc_r > HLC_W'(MAX_LAYERS)) begin
      last_layer = LYR_W'(MAX_LAYERS - 1);
    end else begin
      last_layer = LYR_W'(hlc_r - HLC_W'(1));
    end
  end

  assign ndst     = clampw(wh_r[layer_r]);
  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign out_free = !out_valid_r || !out_stall;

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      layer_r <= '0;
      cnt_r   <= '0;
      nsrc_r  <= WID_W'(1);
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      layer_r <= layer_nxt;
      cnt_r   <= cnt_nxt;
      nsrc_r  <= nsrc_nxt;
      v1_r    <= ctl.rd;
      v2_r    <= v1_r;
    end
  end

  always_comb begin
    state_nxt = state_r;
    layer_nxt = layer_r;
    cnt_nxt   = cnt_r;
    nsrc_nxt  = nsrc_r;
    fv_clr    = 1'b0;
    sig_load  = 1'b0;
    out_load  = 1'b0;
    ctl       = '0;
    ctl.layer = layer_r;
    ctl.row   = cnt_r[NRN_W-1:0];
    ctl.mul   = v1_r;
    ctl.acc   = v2_r;
    case (state_r)
      S_IDLE: begin
        if (accept && in_op == OP_FEED && in_last) begin
          state_nxt = S_INIT;
          layer_nxt = '0;
          cnt_nxt   = '0;
          nsrc_nxt  = clampw(win_r);
        end
      end
      S_INIT: begin
        ctl.clr   = 1'b1;
        state_nxt = S_MAC;
      end
      S_MAC: begin
        ctl.rd = 1'b1;
        if (cnt_r == CNT_W'(nsrc_r - WID_W'(1))) begin
          cnt_nxt   = '0;
          state_nxt = S_D1;
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      S_D1: state_nxt = S_D2;
      S_D2: state_nxt = S_FIN;
      S_FIN: begin
        ctl.fin   = 1'b1;
        state_nxt = S_SHIFT;
      end
      S_SHIFT: begin
        ctl.shift = 1'b1;
        if (cnt_r == CNT_W'(ndst - WID_W'(1))) begin
          cnt_nxt  = '0;
          nsrc_nxt = ndst;
          if (layer_r == last_layer) begin
            state_nxt = S_SIG1;
          end else begin
            layer_nxt = layer_r + LYR_W'(1);
            state_nxt = S_INIT;
          end
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      S_SIG1: begin
        sig_load  = 1'b1;
        fv_clr    = 1'b1;
        state_nxt = S_SIG2;
      end
      S_SIG2: begin
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // feature memory with valid bits, and the hidden memory
  always_ff @(posedge clk) begin
    if (accept && in_op == OP_FEED) begin
      feat[in_row_index] <= in_value;
    end
    if (ctl.rd) begin
      feat_q <= feat[ctl.row];
      hid_q  <= hid[ctl.row];
      sel_r  <= (layer_r == '0);
    end
    if (ctl.shift) begin
      hid[cnt_r[NRN_W-1:0]] <= res[0];
      if (cnt_r == '0) begin
        act0_r <= res[0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || fv_clr) begin
      fv_r <= '0;
      fv_q <= 1'b0;
    end else begin
      if (accept && in_op == OP_FEED) begin
        fv_r[in_row_index] <= 1'b1;
      end
      if (ctl.rd) begin
        fv_q <= fv_r[ctl.row];
      end
    end
  end

  assign act = sel_r ? (fv_q ? feat_q : '0) : hid_q;

  // row of neuron cells
  assign res[MAX_NEURONS] = '0;

  for (genvar c = 0; c < MAX_NEURONS; c++) begin : g_cell
    mlp_cell u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .w_we     (accept && in_op == OP_WEIGHT && in_col_index == NRN_W'(c)),
      .b_we     (accept && in_op == OP_BIAS && in_col_index == NRN_W'(c)),
      .wr_layer (in_layer_index),
      .wr_row   (in_row_index),
      .wr_val   (in_value),
      .act      (act),
      .shift_in (res[c+1]),
      .res      (res[c])
    );
  end

  mlp_sigmoid u_sig (
    .clk   (clk),
    .load  (sig_load),
    .act0  (act0_r),
    .bias  (obias_r),
    .score (score)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      score_r <= score;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_score    = score_r;
  assign out_detected = score_r[15];

endmodule

// File: tb/sv/mlp_inference_relu_sigmoid_unit_tb.sv
// testbench for mlp_inference_relu_sigmoid_unit: loads weights and biases, feeds samples
// and checks each score against a behavioral network model held in a scoreboard class
// depends on mlp_pkg and the unit rtl
`timescale 1ns / 100ps

class mlp_score_board;
  int layers_cfg;
  int win_cfg;
  int wh_cfg[4];
  int obias;
  shortint wt[4][64][64];
  bit wt_ok[4][64][64];
  shortint bs[4][64];
  bit bs_ok[4][64];
  int feat[64];
  int score_q[$];
  bit det_q[$];
  int errors;
  int samples;

  function new();
    layers_cfg = 1;
    win_cfg = 64;
    foreach (wh_cfg[i]) wh_cfg[i] = 64;
    obias = 0;
    foreach (feat[i]) feat[i] = 0;
    errors = 0;
    samples = 0;
  endfunction

  function int eff_layers();
    if (layers_cfg < 1) return 1;
    if (layers_cfg > 4) return 4;
    return layers_cfg;
  endfunction

  function int eff_w(int w);
    if (w < 1) return 1;
    if (w > 64) return 64;
    return w;
  endfunction

  function void set_cfg(logic [2:0] idx, logic [15:0] d);
    case (idx)
      mlp_pkg::CFG_LAYERS: layers_cfg = d[2:0];
      mlp_pkg::CFG_WIN: win_cfg = d[6:0];
      mlp_pkg::CFG_WH1, mlp_pkg::CFG_WH2, mlp_pkg::CFG_WH3, mlp_pkg::CFG_WH4:
        wh_cfg[idx - mlp_pkg::CFG_WH1] = d[6:0];
      mlp_pkg::CFG_OBIAS: obias = $signed(d);
      default: ;
    endcase
  endfunction

  function longint sat16(longint x);
    if (x > 32767) return 32767;
    if (x < -32768) return -32768;
    return x;
  endfunction

  function int curve(int x);
    int knots[17] = '{32767, 40793, 47910, 53580, 57723, 60564, 62427, 63614, 64356,
                      64815, 65096, 65268, 65373, 65436, 65475, 65499, 65513};
    int a, k, f, v;
    a = x < 0 ? -x : x;
    k = a / 128;
    f = a % 128;
    if (k >= 16) v = knots[16];
    else v = knots[k] + ((knots[k+1] - knots[k]) * f) / 128;
    return x < 0 ? 65535 - v : v;
  endfunction

  function int predict_score();
    int src[64];
    int dst[64];
    longint acc, x;
    int n_src, n_dst, idx;
    src = feat;
    foreach (dst[i]) dst[i] = 0;
    n_src = eff_w(win_cfg);
    for (int l = 0; l < eff_layers(); l++) begin
      n_dst = eff_w(wh_cfg[l]);
      for (int c = 0; c < n_dst; c++) begin
        acc = longint'(bs[l][c]) * 256;
        for (int r = 0; r < n_src; r++) acc += longint'(wt[l][r][c]) * longint'(src[r]);
        x = sat16(acc >>> 8);
        dst[c] = x > 0 ? int'(x) : 0;
      end
      src = dst;
      n_src = n_dst;
    end
    x = sat16(longint'(src[0]) + obias);
    if (x < -2048) x = -2048;
    if (x > 2047) x = 2047;
    idx = ((int'(x) + 2048) * 256) / 4096;
    return curve((idx * 4096) / 256 - 2048);
  endfunction

  function void note_request(logic [1:0] op, logic [1:0] l, logic [5:0] r, logic [5:0] c,
                             logic signed [15:0] v, logic last);
    int s;
    case (op)
      mlp_pkg::OP_WEIGHT: begin
        wt[l][r][c] = v;
        wt_ok[l][r][c] = 1;
      end
      mlp_pkg::OP_BIAS: begin
        bs[l][c] = v;
        bs_ok[l][c] = 1;
      end
      mlp_pkg::OP_FEED: begin
        feat[r] = v;
        if (last) begin
          s = predict_score();
          score_q = {score_q, s};
          det_q = {det_q, bit'(s > 32767)};
          foreach (feat[i]) feat[i] = 0;
          samples++;
        end
      end
      default: ;
    endcase
  endfunction

  function void check_result(logic [15:0] score, logic detected);
    int s;
    bit d;
    if (score_q.size() == 0) begin
      $error("unexpected result score=%0d detected=%0d", score, detected);
      errors++;
      return;
    end
    s = score_q.pop_front();
    d = det_q.pop_front();
    if (score !== s[15:0]) begin
      $error("score: expected %0d actual %0d", s, score);
      errors++;
    end
    if (detected !== d) begin
      $error("detected: expected %0d actual %0d", d, detected);
      errors++;
    end
  endfunction
endclass

module mlp_inference_relu_sigmoid_unit_tb;
  import mlp_pkg::*;

  localparam logic [1:0] OP_NOP = 2'd3;

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_stall;
  logic [1:0] in_op = 0;
  logic [1:0] in_layer_index = 0;
  logic [5:0] in_row_index = 0;
  logic [5:0] in_col_index = 0;
  logic signed [15:0] in_value = 0;
  logic in_last = 0;
  logic out_valid;
  logic out_stall = 0;
  logic [15:0] out_score;
  logic out_detected;
  logic cfg_we = 0;
  logic [CIDX_W-1:0] cfg_index = 0;
  logic [CFG_W-1:0] cfg_data = 0;

  mlp_score_board sb = new();
  bit quiet = 0;
  int items = 0;
  int phases = 0;
  int stall_left = 0;

  mlp_inference_relu_sigmoid_unit u_top (.*);

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  initial begin
    #5000000;
    $display("** mlp_inference_relu_sigmoid_unit: FAILED **");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_score, out_detected);
    if (quiet) begin
      out_stall <= 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 12);
      out_stall <= 1;
    end else begin
      out_stall <= 0;
    end
  end

  function automatic logic [15:0] rnd_val();
    case ($urandom_range(0, 3))
      0: return 16'($urandom);
      1: return 16'($urandom_range(0, 1023));
      default: return 16'($urandom_range(0, 1023) - 512);
    endcase
  endfunction

  task automatic send(logic [1:0] op, logic [1:0] l, logic [5:0] r, logic [5:0] c,
                      logic [15:0] v, logic last);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_valid <= 1;
    in_op <= op;
    in_layer_index <= l;
    in_row_index <= r;
    in_col_index <= c;
    in_value <= v;
    in_last <= last;
    do @(posedge clk); while (in_stall);
    sb.note_request(op, l, r, c, v, last);
    items++;
  endtask

  task automatic wait_idle();
    in_valid <= 0;
    while (sb.score_q.size() > 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic set_phase(int nl, int wi, int w1, int w2, int w3, int w4, int ob);
    logic [15:0] vals[7];
    vals = '{16'(nl), 16'(wi), 16'(w1), 16'(w2), 16'(w3), 16'(w4), 16'(ob)};
    wait_idle();
    for (int i = 0; i < 7; i++) begin
      cfg_we <= 1;
      cfg_index <= CIDX_W'(i);
      cfg_data <= vals[i];
      @(posedge clk);
      sb.set_cfg(CIDX_W'(i), vals[i]);
    end
    cfg_we <= 0;
    phases++;
  endtask

  task automatic fill_missing();
    int n_src, n_dst;
    n_src = sb.eff_w(sb.win_cfg);
    for (int l = 0; l < sb.eff_layers(); l++) begin
      n_dst = sb.eff_w(sb.wh_cfg[l]);
      for (int c = 0; c < n_dst; c++) begin
        if (!sb.bs_ok[l][c]) send(OP_BIAS, 2'(l), 6'($urandom), 6'(c), rnd_val(), 0);
        for (int r = 0; r < n_src; r++)
          if (!sb.wt_ok[l][r][c]) send(OP_WEIGHT, 2'(l), 6'(r), 6'(c), rnd_val(), 0);
      end
      n_src = n_dst;
    end
  endtask

  task automatic rnd_sample();
    int n;
    n = $urandom_range(0, 6);
    repeat (n)
      send($urandom_range(0, 1) ? OP_WEIGHT : OP_BIAS, 2'($urandom), 6'($urandom),
           6'($urandom), rnd_val(), 1'($urandom));
    fill_missing();
    n = $urandom_range(0, 8);
    repeat (n) begin
      if ($urandom_range(0, 9) == 0)
        send(OP_NOP, 2'($urandom), 6'($urandom), 6'($urandom), 16'($urandom), 1'($urandom));
      else
        send(OP_FEED, 2'($urandom), 6'($urandom_range(0, 1) ? $urandom_range(0, 7) : $urandom),
             6'($urandom), rnd_val(), 0);
    end
    send(OP_FEED, 2'($urandom), 6'($urandom_range(0, 7)), 6'($urandom), rnd_val(), 1);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    set_phase(1, 2, 1, 3, 3, 3, 0);
    send(OP_WEIGHT, 0, 0, 0, 16'sd256, 0);
    send(OP_WEIGHT, 0, 1, 0, -16'sd32768, 1);
    send(OP_BIAS, 0, 0, 0, 16'sd0, 1);
    send(OP_NOP, 3, 63, 63, 16'hffff, 1);
    send(OP_FEED, 0, 0, 0, 16'sd32767, 0);
    send(OP_FEED, 0, 63, 0, -16'sd32768, 1);
    send(OP_FEED, 0, 1, 0, -16'sd32768, 1);
    send(OP_BIAS, 0, 0, 0, 16'sd32767, 0);
    send(OP_FEED, 3, 0, 63, 16'sd0, 1);
    send(OP_BIAS, 0, 0, 0, 16'sd512, 0);
    send(OP_WEIGHT, 0, 0, 0, 16'sd32767, 0);
    send(OP_FEED, 0, 0, 0, 16'sd100, 1);

    set_phase(1, 1, 64, 1, 1, 1, -32768);
    rnd_sample();
    set_phase(1, 64, 1, 1, 1, 1, 32767);
    rnd_sample();
    set_phase(0, 100, 0, 0, 0, 0, 0);
    rnd_sample();
    set_phase(7, 2, 2, 2, 2, 127, -300);
    rnd_sample();

    while (items < 950) begin
      set_phase($urandom_range(0, 7), $urandom_range(1, 6), $urandom_range(1, 6),
                $urandom_range(1, 6), $urandom_range(0, 6), $urandom_range(1, 6),
                $urandom_range(0, 3) == 0 ? int'(16'($urandom)) : $urandom_range(0, 600) - 300);
      repeat ($urandom_range(2, 6)) begin
        if (items > 850) quiet = 1;
        rnd_sample();
      end
    end

    wait_idle();
    repeat (600) @(posedge clk);
    $display("ran %0d requests over %0d settings, %0d samples scored",
             items, phases, sb.samples);
    if (sb.errors == 0 && sb.score_q.size() == 0) begin
      $display("** mlp_inference_relu_sigmoid_unit: PASSED **");
    end else begin
      $display("** mlp_inference_relu_sigmoid_unit: FAILED **");
    end
    $finish;
  end
endmodule

// File: filelist.f
src/mlp_pkg.sv
src/mlp_cell.sv
src/mlp_sigmoid.sv
src/mlp_inference_relu_sigmoid_unit.sv
tb/sv/mlp_inference_relu_sigmoid_unit_tb.sv
